FILE: rtl/core/bls_pkg.sv
package bls_pkg;

  // polynomial and history width, one cell per coefficient
  localparam int unsigned POLY_W = 64;
  // result width of the complexity field
  localparam int unsigned LC_W   = 7;
  // symbol width on the input channel
  localparam int unsigned SYM_W  = 8;

  typedef logic [POLY_W-1:0] poly_t;
  typedef logic [LC_W-1:0]   lc_t;
  typedef logic [SYM_W-1:0]  sym_t;

  // per-request control broadcast to every cell
  typedef struct packed {
    logic load;        // request accepted this cycle
    logic clear;       // start of a new sequence
    logic advance;     // bit taken (not past the sequence limit)
    logic disc;        // discrepancy of this bit
    logic len_change;  // complexity changes: B takes the old C
  } cell_ctrl_t;

endpackage

FILE: rtl/core/bls_in_if.sv
interface bls_in_if;
  import bls_pkg::*;

  logic valid;
  logic ready;
  sym_t symbol_value;
  logic start_of_sequence;

  modport source (output valid, output symbol_value, output start_of_sequence, input ready);
  modport sink   (input valid, input symbol_value, input start_of_sequence, output ready);
endinterface

FILE: rtl/core/bls_out_if.sv
interface bls_out_if;
  import bls_pkg::*;

  logic  valid;
  logic  ready;
  lc_t   linear_complexity;
  poly_t connection_poly;
  logic  discrepancy;
  logic  overflow;

  modport source (output valid, output linear_complexity, output connection_poly,
                  output discrepancy, output overflow, input ready);
  modport sink   (input valid, input linear_complexity, input connection_poly,
                  input discrepancy, input overflow, output ready);
endinterface

FILE: rtl/core/bls_cell.sv
// One coefficient slice: c[i], the pre-shifted B bit and one history bit.
module bls_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bls_pkg::cell_ctrl_t ctrl,
  input  logic                left_c,
  input  logic                left_b,
  input  logic                left_h,
  output logic                eff_c,
  output logic                eff_b,
  output logic                eff_h,
  output logic                c_nxt
);
  import bls_pkg::*;

  localparam logic C_INIT = (IDX == 0);
  localparam logic B_INIT = (IDX == 1);

  logic c_r, b_r, h_r;
  logic b_nxt, h_nxt;

  // state as seen by this request, after an optional sequence restart
  assign eff_c = ctrl.clear ? C_INIT : c_r;
  assign eff_b = ctrl.clear ? B_INIT : b_r;
  assign eff_h = ctrl.clear ? 1'b0   : h_r;

  // C ^= B*x^(N-m); B shifts one place or reloads from old C; history shifts
  always_comb begin
    c_nxt = eff_c;
    b_nxt = eff_b;
    h_nxt = eff_h;
    if (ctrl.advance) begin
      c_nxt = eff_c ^ (ctrl.disc & eff_b);
      b_nxt = ctrl.len_change ? left_c : left_b;
      h_nxt = left_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= C_INIT;
      b_r <= B_INIT;
      h_r <= 1'b0;
    end else if (ctrl.load) begin
      c_r <= c_nxt;
      b_r <= b_nxt;
      h_r <= h_nxt;
    end
  end

endmodule

FILE: rtl/core/binary_lfsr_synthesis.sv
// Binary Berlekamp-Massey LFSR synthesis.
// in_ch (valid/ready) carries one symbol per request; bit 0, XORed with the
// invert_input register (cfg_we/cfg_wdata, write while idle), is the next
// sequence bit. start_of_sequence restarts the analysis with this bit.
// Each request yields one result on out_ch: linear complexity L, the
// connection polynomial C, the discrepancy and an overflow flag set when the
// bit was dropped because SEQ_MAX bits were already taken.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle unless the receiver stalls; the full update
// (64-term parity, polynomial XOR, B shift) is combinational across a row of 64
// cells, B being held pre-shifted by N-m so no barrel shifter is needed.
// A single output register decouples the channels: in_ch.ready stays high
// while the result register is empty or being drained; when the receiver
// stalls, the result holds and input is held off until it is taken.
// Reset (rst_n low, synchronous) empties the output, restores C = 1 and the
// pre-shifted B = x, clears history, L and the bit count, and clears invert_input.
module binary_lfsr_synthesis #(
  parameter int unsigned SEQ_MAX = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bls_in_if.sink    in_ch,
  bls_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import bls_pkg::*;

  localparam int unsigned CNT_W = $clog2(SEQ_MAX + 1);

  logic             invert_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_e;
  logic [CNT_W-1:0] lc_r, lc_nxt, lc_e;
  logic             out_valid_r;
  lc_t              out_lc_r;
  poly_t            out_poly_r;
  logic             out_disc_r, out_ovf_r;

  logic             accept, bit_in, ovf, disc;
  logic [POLY_W-1:0] c_e, b_e, h_e, c_nxt;
  logic [POLY_W-1:0] left_c, left_b, left_h;
  logic [POLY_W-1:0] terms;
  lc_t              lc_ext;
  cell_ctrl_t       ctrl;

  // handshake: take a request whenever the result register can move
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign bit_in = in_ch.symbol_value[0] ^ invert_r;
  assign cnt_e  = in_ch.start_of_sequence ? '0 : cnt_r;
  assign lc_e   = in_ch.start_of_sequence ? '0 : lc_r;
  assign lc_ext = LC_W'(lc_e);
  assign ovf    = (CNT_W+1)'(cnt_e) >= (CNT_W+1)'(SEQ_MAX);

  // discrepancy terms c[k+1] & s[N-1-k] for k < L
  genvar k;
  generate
    for (k = 0; k < POLY_W; k++) begin : g_term
      if (k < POLY_W - 1) begin : g_live
        localparam lc_t KIDX = LC_W'(k);
        assign terms[k] = c_e[k+1] & h_e[k] & (KIDX < lc_ext);
      end else begin : g_top
        assign terms[k] = 1'b0;
      end
    end
  endgenerate

  assign disc = !ovf && (bit_in ^ (^terms));

  // cell control
  always_comb begin
    ctrl.load       = accept;
    ctrl.clear      = in_ch.start_of_sequence;
    ctrl.advance    = accept && !ovf;
    ctrl.disc       = disc;
    ctrl.len_change = disc && (((CNT_W+1)'(lc_e) << 1) <= (CNT_W+1)'(cnt_e));
  end

  // neighbor wiring: cell 0 takes the new bit into the history
  assign left_c = {c_e[POLY_W-2:0], 1'b0};
  assign left_b = {b_e[POLY_W-2:0], 1'b0};
  assign left_h = {h_e[POLY_W-2:0], bit_in};

  generate
    for (k = 0; k < POLY_W; k++) begin : g_cell
      bls_cell #(.IDX(k)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .left_c (left_c[k]),
        .left_b (left_b[k]),
        .left_h (left_h[k]),
        .eff_c  (c_e[k]),
        .eff_b  (b_e[k]),
        .eff_h  (h_e[k]),
        .c_nxt  (c_nxt[k])
      );
    end
  endgenerate

  // complexity and bit count
  always_comb begin
    lc_nxt  = lc_e;
    cnt_nxt = cnt_e;
    if (ctrl.advance) begin
      cnt_nxt = CNT_W'((CNT_W+1)'(cnt_e) + 1'b1);
      if (ctrl.len_change) begin
        lc_nxt = CNT_W'((CNT_W+1)'(cnt_e) + 1'b1 - (CNT_W+1)'(lc_e));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      lc_r     <= '0;
      invert_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
        lc_r  <= lc_nxt;
      end
      if (cfg_we) begin
        invert_r <= cfg_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_lc_r   <= LC_W'(lc_nxt);
      out_poly_r <= c_nxt;
      out_disc_r <= disc;
      out_ovf_r  <= ovf;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.linear_complexity = out_lc_r;
  assign out_ch.connection_poly   = out_poly_r;
  assign out_ch.discrepancy       = out_disc_r;
  assign out_ch.overflow          = out_ovf_r;

endmodule

FILE: rtl/core/bls_checker.sv
module bls_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bls_pkg::lc_t       lc,
  input bls_pkg::poly_t     poly,
  input logic               disc,
  input logic               ovf
);
  import bls_pkg::*;

  // a request always produces a result in the next cycle
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request produced no result");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(lc) && $stable(poly)
                                   && $stable(disc) && $stable(ovf)))
    else $error("stalled result changed");

  // constant term of C is always one
  a_poly_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> poly[0])
    else $error("connection polynomial lost its constant term");

  // a dropped bit carries no discrepancy, and L never exceeds 64
  a_ovf_disc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(ovf && disc) && (lc <= LC_W'(POLY_W))))
    else $error("bad overflow/discrepancy or complexity out of range");

endmodule

bind binary_lfsr_synthesis bls_checker u_bls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .lc        (out_ch.linear_complexity),
  .poly      (out_ch.connection_poly),
  .disc      (out_ch.discrepancy),
  .ovf       (out_ch.overflow)
);
